// ===== rtl/core/length_prefixed_word_deframer_core_defines.svh =====
// Assertion macros shared by the checker of the deframer core.
`ifndef LENGTH_PREFIXED_WORD_DEFRAMER_CORE_DEFINES_SVH
`define LENGTH_PREFIXED_WORD_DEFRAMER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define LPWD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define LPWD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/lpwd_pkg.sv =====
package lpwd_pkg;

	// Width of the decoded length field and of the length counters.
	localparam int WORD_LEN_W = 29;
	// Number of significant length bits; longer lengths saturate.
	localparam int LENGTH_BITS = 29;

	localparam logic [WORD_LEN_W-1:0] LEN_MAX =
		WORD_LEN_W'((64'd1 << LENGTH_BITS) - 64'd1);

	// Flag patterns of the first prefix byte.
	localparam logic [7:0] PFX4_FLAGS = 8'he0;
	localparam logic [7:0] PFX3_FLAGS = 8'hc0;
	localparam logic [7:0] PFX2_FLAGS = 8'h80;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'b001,
		PH_PREFIX  = 3'b010,
		PH_PAYLOAD = 3'b100
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0]            out_byte;
		logic                  is_payload;
		logic                  length_valid;
		logic [WORD_LEN_W-1:0] word_length;
		logic                  word_done;
		logic                  sentence_done;
	} out_item_t;

	// Contents of the input stage register.
	typedef struct packed {
		logic       valid;
		logic [7:0] data_byte;
	} stage_t;

	function automatic logic [WORD_LEN_W-1:0] saturate_len(input logic [WORD_LEN_W-1:0] v);
		logic [WORD_LEN_W-1:0] r;
		r = (v > LEN_MAX) ? LEN_MAX : v;
		return r;
	endfunction

endpackage

// ===== rtl/core/lpwd_in_if.sv =====
interface lpwd_in_if;
	logic               valid;
	logic               ready;
	lpwd_pkg::in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/lpwd_out_if.sv =====
interface lpwd_out_if;
	logic                valid;
	logic                ready;
	lpwd_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/lpwd_in_stage.sv =====
module lpwd_in_stage (
	input  logic               clk,
	input  logic               arst_n,
	lpwd_in_if.sink            byte_in,
	input  logic               advance,
	output lpwd_pkg::stage_t   stage
);

	logic       valid_s1;
	logic [7:0] byte_s1;

	// A new byte may enter when the stage is empty or drains this cycle.
	assign byte_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_in.ready) begin
			valid_s1 <= byte_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_in.ready && byte_in.valid) begin
			byte_s1 <= byte_in.data.data_byte;
		end
	end

	assign stage.valid     = valid_s1;
	assign stage.data_byte = byte_s1;

endmodule

// ===== rtl/core/lpwd_decode.sv =====
module lpwd_decode (
	input  logic                clk,
	input  logic                arst_n,
	input  lpwd_pkg::stage_t    stage,
	input  logic                advance,
	output lpwd_pkg::out_item_t result
);

	localparam int W = lpwd_pkg::WORD_LEN_W;

	lpwd_pkg::phase_t phase_q, phase_d;
	logic [1:0]       prefix_left_q, prefix_left_d;
	logic [W-1:0]     acc_q, acc_d;
	logic [W-1:0]     payload_left_q, payload_left_d;

	logic             fin;
	logic [W-1:0]     fin_raw;
	logic [W-1:0]     fin_val;
	logic [W-1:0]     pay_dec;
	logic [1:0]       pfx_dec;
	logic [W-1:0]     acc_shift;
	logic [7:0]       b;

	assign b         = stage.data_byte;
	assign pay_dec   = (payload_left_q != '0) ? payload_left_q - W'(1) : '0;
	assign pfx_dec   = (prefix_left_q != '0) ? prefix_left_q - 2'd1 : 2'd0;
	assign acc_shift = {acc_q[W-9:0], b};

	always_comb begin
		phase_d             = phase_q;
		prefix_left_d       = prefix_left_q;
		acc_d               = acc_q;
		payload_left_d      = payload_left_q;
		fin                 = 1'b0;
		fin_raw             = '0;
		result              = '0;
		result.out_byte     = b;

		case (phase_q)
			lpwd_pkg::PH_PAYLOAD: begin
				result.is_payload  = 1'b1;
				result.word_length = acc_q;
				payload_left_d     = pay_dec;
				if (pay_dec == '0) begin
					result.word_done = 1'b1;
					phase_d          = lpwd_pkg::PH_IDLE;
				end
			end
			lpwd_pkg::PH_PREFIX: begin
				acc_d         = acc_shift;
				prefix_left_d = pfx_dec;
				if (pfx_dec == 2'd0) begin
					fin     = 1'b1;
					fin_raw = acc_shift;
				end
			end
			default: begin
				// Idle, and the unreachable leftover code, read a first prefix byte.
				if ((b & lpwd_pkg::PFX4_FLAGS) == lpwd_pkg::PFX4_FLAGS) begin
					acc_d         = W'(b[4:0]);
					prefix_left_d = 2'd3;
					phase_d       = lpwd_pkg::PH_PREFIX;
				end else if ((b & lpwd_pkg::PFX3_FLAGS) == lpwd_pkg::PFX3_FLAGS) begin
					acc_d         = W'(b[4:0]);
					prefix_left_d = 2'd2;
					phase_d       = lpwd_pkg::PH_PREFIX;
				end else if ((b & lpwd_pkg::PFX2_FLAGS) == lpwd_pkg::PFX2_FLAGS) begin
					acc_d         = W'(b[5:0]);
					prefix_left_d = 2'd1;
					phase_d       = lpwd_pkg::PH_PREFIX;
				end else begin
					fin     = 1'b1;
					fin_raw = W'(b[6:0]);
				end
			end
		endcase

		fin_val = lpwd_pkg::saturate_len(fin_raw);

		// Prefix complete: an empty word closes the sentence at once.
		if (fin) begin
			acc_d               = fin_val;
			prefix_left_d       = 2'd0;
			result.length_valid = 1'b1;
			result.word_length  = fin_val;
			if (fin_val == '0) begin
				result.word_done     = 1'b1;
				result.sentence_done = 1'b1;
				payload_left_d       = '0;
				phase_d              = lpwd_pkg::PH_IDLE;
			end else begin
				payload_left_d = fin_val;
				phase_d        = lpwd_pkg::PH_PAYLOAD;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= lpwd_pkg::PH_IDLE;
			prefix_left_q  <= 2'd0;
			acc_q          <= '0;
			payload_left_q <= '0;
		end else if (stage.valid && advance) begin
			phase_q        <= phase_d;
			prefix_left_q  <= prefix_left_d;
			acc_q          <= acc_d;
			payload_left_q <= payload_left_d;
		end
	end

endmodule

// ===== rtl/core/lpwd_out_stage.sv =====
module lpwd_out_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load_valid,
	input  lpwd_pkg::out_item_t result,
	output logic                advance,
	lpwd_out_if.source          word_out
);

	logic                valid_q;
	lpwd_pkg::out_item_t data_q;

	// The result register takes a new value when empty or being read.
	assign advance = !valid_q || word_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= load_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && load_valid) begin
			data_q <= result;
		end
	end

	assign word_out.valid = valid_q;
	assign word_out.data  = data_q;

endmodule

// ===== rtl/core/length_prefixed_word_deframer_core.sv =====
// Length-prefixed word deframer.
// byte_in carries one received byte per transfer (valid/ready). word_out
// returns exactly one result per byte: the byte itself, whether it is prefix
// or payload, the decoded word length, and word-end and sentence-end marks.
// A word starts with a big-endian length prefix of 1 to 4 bytes chosen by
// the top bits of its first byte; a zero length ends a sentence.
// Each byte passes through one input register and one result register,
// with the state update between, before its result is offered on word_out.
// Throughput is one byte per cycle while word_out does not stall, set by
// the single per-byte state update between these two registers.
// When word_out stalls, the result register holds and the input register
// still takes one more byte, so up to two bytes sit inside the block; then
// byte_in.ready drops until word_out drains.
// Reset (arst_n low, asynchronous) empties both registers and returns the
// decoder to waiting for the first prefix byte of a new word.
module length_prefixed_word_deframer_core (
	input  logic       clk,
	input  logic       arst_n,
	lpwd_in_if.sink    byte_in,
	lpwd_out_if.source word_out
);

	lpwd_pkg::stage_t    stage;
	lpwd_pkg::out_item_t result;
	logic                advance;

	// Input register: holds the byte being decoded this cycle.
	lpwd_in_stage u_in_stage (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_in (byte_in),
		.advance (advance),
		.stage   (stage)
	);

	// Decoder state and the per-byte result logic. The state moves only
	// when the staged byte actually passes into the result register.
	lpwd_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.stage   (stage),
		.advance (advance),
		.result  (result)
	);

	// Result register driving word_out; its readiness paces the pipeline.
	lpwd_out_stage u_out_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (stage.valid),
		.result     (result),
		.advance    (advance),
		.word_out   (word_out)
	);

endmodule

// ===== rtl/core/lpwd_checker.sv =====
`include "length_prefixed_word_deframer_core_defines.svh"

module lpwd_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_ready,
	input lpwd_pkg::out_item_t out_data
);

	`LPWD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
	`LPWD_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_data), "result changed while stalled")
	`LPWD_ASSERT_NOW(a_sentence_end, out_valid && out_data.sentence_done, out_data.word_done && out_data.length_valid && (out_data.word_length == '0), "sentence end without empty word")
	`LPWD_ASSERT_NOW(a_payload_no_len, out_valid && out_data.is_payload, !out_data.length_valid && !out_data.sentence_done, "payload byte flagged as prefix end")

endmodule

bind length_prefixed_word_deframer_core lpwd_checker u_lpwd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (word_out.valid),
	.out_ready (word_out.ready),
	.out_data  (word_out.data)
);
